>>> design/pcfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfl_pkg - shared types and constants
// Status codes, register indexes, reset values and the back-end state type
// of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

    localparam int LOW_W  = 20;
    localparam int TOP_W  = 21;
    localparam int ADDR_W = 32;
    localparam int FROM_W = 3;

    localparam logic [LOW_W-1:0] LOW_PAGE_RST = 20'd524288;
    localparam logic [TOP_W-1:0] TOP_PAGE_RST = 21'd557056;

    // register index, taken from paddr[2]
    localparam logic CFG_LOW_PAGE = 1'b0;
    localparam logic CFG_TOP_PAGE = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOMEM  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic is_free;
        logic reject;
    } t_op_class;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } t_back_state;

endpackage
`default_nettype wire

>>> design/pcfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfl_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module pcfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/pcfl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfl_front - request classifier
// Folds the CPU number into range, checks a free address against the page
// window and turns it into a next-link table index.
// ----------------------------------------------------------------------------
module pcfl_front
    import pcfl_pkg::*;
#(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_SHIFT = 12,
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1,
    localparam int IW = $clog2(PAGES)
) (
    input  wire                 i_cmd,
    input  wire [2:0]           i_cpu,
    input  wire [ADDR_W-1:0]    i_addr,
    input  wire [LOW_W-1:0]     i_low_page,
    input  wire [TOP_W-1:0]     i_top_page,
    output t_op_class           o_cls,
    output logic [CW-1:0]       o_cpu,
    output logic [IW-1:0]       o_idx
);

    logic [2:0]       cpu_fold;
    logic [CW+2:0]    cpu_ext;
    logic             misalign;
    logic [TOP_W-1:0] page_x;
    logic [TOP_W-1:0] low_x;
    logic [TOP_W-1:0] diff;
    logic             below;
    logic             above;
    logic             outside;

    // cpu is at most 7, so a few conditional subtracts fold it
    always_comb begin
        cpu_fold = i_cpu;
        for (int i = 0; i < 8; i++) begin
            if (int'(cpu_fold) >= CPUS) begin
                cpu_fold = cpu_fold - 3'(CPUS);
            end
        end
    end

    assign cpu_ext  = {{CW{1'b0}}, cpu_fold};
    assign o_cpu    = cpu_ext[CW-1:0];

    assign misalign = |i_addr[PAGE_SHIFT-1:0];
    assign page_x   = TOP_W'(i_addr[ADDR_W-1:PAGE_SHIFT]);
    assign low_x    = {1'b0, i_low_page};
    assign diff     = page_x - low_x;
    assign below    = page_x < low_x;
    assign above    = page_x >= i_top_page;
    assign outside  = diff >= TOP_W'(PAGES);

    assign o_idx         = diff[IW-1:0];
    assign o_cls.is_free = (i_cmd == CMD_FREE);
    assign o_cls.reject  = (i_cmd == CMD_FREE) && (misalign || below || above || outside);

endmodule
`default_nettype wire

>>> design/pcfl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfl_queue - two-entry request queue
// Decouples the classifier from the list engine.
// ----------------------------------------------------------------------------
module pcfl_queue #(
    parameter int WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire [WIDTH-1:0]     i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output logic [WIDTH-1:0]    o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> design/pcfl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfl_back - list engine
// Holds the per-CPU list heads and the next-link RAM, pushes freed pages,
// pops (or steals) pages on allocate, and drives the result register.
// ----------------------------------------------------------------------------
module pcfl_back
    import pcfl_pkg::*;
#(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_SHIFT = 12,
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1,
    localparam int IW = $clog2(PAGES)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  wire t_op_class      i_q_cls,
    input  wire [CW-1:0]        i_q_cpu,
    input  wire [IW-1:0]        i_q_idx,
    output logic                o_q_pop,
    input  wire [LOW_W-1:0]     i_low_page,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [ADDR_W-1:0]   o_page_addr,
    output logic [FROM_W-1:0]   o_from_cpu
);

    t_back_state        r_state;
    t_back_state        n_state;

    logic [CPUS-1:0]    r_head_ok;
    logic [IW-1:0]      r_head_idx [CPUS];
    logic [CW-1:0]      r_sel;
    logic [IW-1:0]      r_pop_idx;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [ADDR_W-1:0]  r_page_addr;
    logic [CW-1:0]      r_from;

    logic               out_free;
    logic [CPUS-1:0]    masked;
    logic [CPUS-1:0]    pick;
    logic [CPUS-1:0]    first;
    logic [CW-1:0]      sel_c;
    logic               hit;
    logic [CW-1:0]      rd_sel;
    logic [IW-1:0]      head_idx_rd;

    logic               ram_we;
    logic               ram_re;
    logic [IW:0]        ram_rdata;

    logic               head_we;
    logic [CW-1:0]      head_wsel;
    logic               head_wok;
    logic [IW-1:0]      head_widx;
    logic               ld_res;
    logic [1:0]         res_status;
    logic [ADDR_W-1:0]  res_addr;
    logic [CW-1:0]      res_from;
    logic               take_pop;

    logic [TOP_W-1:0]            page_sum;
    logic [TOP_W+PAGE_SHIFT-1:0] page_sh;
    logic [CW+FROM_W-1:0]        from_ext;

    assign out_free = !r_out_valid || !i_out_stall;

    // round-robin pick: first non-empty list at or after the requester
    always_comb begin
        for (int i = 0; i < CPUS; i++) begin
            masked[i] = r_head_ok[i] && (i >= int'(i_q_cpu));
        end
    end

    assign pick  = (|masked) ? masked : r_head_ok;
    assign first = pick & (~pick + CPUS'(1));
    assign hit   = |r_head_ok;

    always_comb begin
        sel_c = '0;
        for (int i = 0; i < CPUS; i++) begin
            if (first[i]) begin
                sel_c = sel_c | CW'(i);
            end
        end
    end

    assign rd_sel      = i_q_cls.is_free ? i_q_cpu : sel_c;
    assign head_idx_rd = r_head_idx[rd_sel];

    assign page_sum = {1'b0, i_low_page} + TOP_W'(r_pop_idx);
    assign page_sh  = {page_sum, {PAGE_SHIFT{1'b0}}};

    pcfl_ram #(
        .WIDTH (IW + 1),
        .DEPTH (PAGES)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_idx),
        .i_wdata ({r_head_ok[i_q_cpu], head_idx_rd}),
        .i_re    (ram_re),
        .i_raddr (head_idx_rd),
        .o_rdata (ram_rdata)
    );

    assign take_pop = i_q_valid && out_free && !i_q_cls.reject && !i_q_cls.is_free && hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (take_pop) begin
                    n_state = BK_POP;
                end
            end
            BK_POP:  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        head_we    = 1'b0;
        head_wsel  = i_q_cpu;
        head_wok   = 1'b1;
        head_widx  = i_q_idx;
        ld_res     = 1'b0;
        res_status = ST_OK;
        res_addr   = '0;
        res_from   = '0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_cls.reject) begin
                        ld_res     = 1'b1;
                        res_status = ST_REJECT;
                    end else if (i_q_cls.is_free) begin
                        ram_we  = 1'b1;
                        head_we = 1'b1;
                        ld_res  = 1'b1;
                    end else if (hit) begin
                        ram_re = 1'b1;
                    end else begin
                        ld_res     = 1'b1;
                        res_status = ST_NOMEM;
                    end
                end
            end
            BK_POP: begin
                // output register was emptied when the pop started
                head_we   = 1'b1;
                head_wsel = r_sel;
                head_wok  = ram_rdata[IW];
                head_widx = ram_rdata[IW-1:0];
                ld_res    = 1'b1;
                res_addr  = page_sh[ADDR_W-1:0];
                res_from  = r_sel;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head_ok   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (head_we) begin
                r_head_ok[head_wsel] <= head_wok;
            end
            if (ld_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_idx[head_wsel] <= head_widx;
        end
        if (take_pop && r_state == BK_IDLE) begin
            r_sel     <= sel_c;
            r_pop_idx <= head_idx_rd;
        end
        if (ld_res) begin
            r_status    <= res_status;
            r_page_addr <= res_addr;
            r_from      <= res_from;
        end
    end

    assign from_ext    = {{FROM_W{1'b0}}, r_from};
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_page_addr = r_page_addr;
    assign o_from_cpu  = from_ext[FROM_W-1:0];

`ifndef SYNTHESIS
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_POP |=> r_state == BK_IDLE)
        else $error("pop phase lasted more than one cycle");

    a_pop_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_POP |-> !r_out_valid)
        else $error("result register busy during pop");

    a_pop_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_POP |-> r_head_ok[r_sel])
        else $error("pop from an empty list");

    a_no_pop_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_POP |-> !o_q_pop)
        else $error("queue popped while a pop is in flight");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

>>> design/per_cpu_page_free_list_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_core - per-CPU page free-list allocator
// LIFO free list per CPU in a shared next-link RAM, with stealing from the
// other CPUs' lists on an empty local list.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Beat
//  request   i_in_valid / o_in_stall      i_cmd, i_cpu, i_addr
//  result    o_out_valid / i_out_stall    o_status, o_page_addr, o_from_cpu
//  config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  Free and rejected requests finish in the list engine from idle; an allocate
//  that hits takes a registered next-link RAM read, then a head update.
//  A two-entry queue between classifier and list engine absorbs stalls.
//  Reset clears the list heads; next-link RAM contents are never cleared.
//  The result register is reloaded as soon as the previous beat is taken.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_core
    import pcfl_pkg::*;
#(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_cmd,
    input  wire [2:0]           i_cpu,
    input  wire [ADDR_W-1:0]    i_addr,

    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [1:0]          o_status,
    output logic [ADDR_W-1:0]   o_page_addr,
    output logic [FROM_W-1:0]   o_from_cpu,

    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int IW = $clog2(PAGES);
    localparam int QW = 2 + CW + IW;

    logic [LOW_W-1:0] r_low_page;
    logic [TOP_W-1:0] r_top_page;

    t_op_class        f_cls;
    logic [CW-1:0]    f_cpu;
    logic [IW-1:0]    f_idx;

    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_data;
    t_op_class        q_cls;
    logic [CW-1:0]    q_cpu;
    logic [IW-1:0]    q_idx;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_page <= LOW_PAGE_RST;
            r_top_page <= TOP_PAGE_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_TOP_PAGE) begin
                r_top_page <= pwdata[TOP_W-1:0];
            end else begin
                r_low_page <= pwdata[LOW_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_TOP_PAGE) ? {{(32-TOP_W){1'b0}}, r_top_page}
                                               : {{(32-LOW_W){1'b0}}, r_low_page};

    pcfl_front #(
        .CPUS       (CPUS),
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_cmd      (i_cmd),
        .i_cpu      (i_cpu),
        .i_addr     (i_addr),
        .i_low_page (r_low_page),
        .i_top_page (r_top_page),
        .o_cls      (f_cls),
        .o_cpu      (f_cpu),
        .o_idx      (f_idx)
    );

    assign o_in_stall = q_full;

    pcfl_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  ({f_cls, f_cpu, f_idx}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_cls = q_data[QW-1:QW-2];
    assign q_cpu = q_data[CW+IW-1:IW];
    assign q_idx = q_data[IW-1:0];

    pcfl_back #(
        .CPUS       (CPUS),
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cls     (q_cls),
        .i_q_cpu     (q_cpu),
        .i_q_idx     (q_idx),
        .o_q_pop     (q_pop),
        .i_low_page  (r_low_page),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_page_addr (o_page_addr),
        .o_from_cpu  (o_from_cpu)
    );

endmodule
`default_nettype wire
